// ===== src/jdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// jdcd_pkg: shared constants for the day-count to calendar-date converter
// Field widths, stream packing and calendar constants used by the datapath
// and the interface checker.
// ----------------------------------------------------------------------------
package jdcd_pkg;

	// Width of the day count taken from the input stream
	localparam int DAY_BITS = 39;
	localparam int IN_W     = ((DAY_BITS + 7) / 8) * 8;

	// Result fields and their placement in m_tdata (lowest bit up)
	localparam int DOM_W         = 5;
	localparam int MON_W         = 4;
	localparam int YEAR_NUMBER_W = 31;
	localparam int DOM_LSB       = 0;
	localparam int MON_LSB       = DOM_LSB + DOM_W;
	localparam int YEAR_LSB      = MON_LSB + MON_W;
	localparam int BC_BIT        = YEAR_LSB + YEAR_NUMBER_W;
	localparam int OUT_FIELDS_W  = BC_BIT + 1;
	localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Pipeline depth, input register to result register
	localparam int STAGES = 10;

	// Calendar switch: last Julian day, and offset that maps the first
	// Gregorian day onto its day count from 1 January 1200
	localparam logic [DAY_BITS-1:0] LAST_JULIAN_DAY = DAY_BITS'(2299160);
	localparam logic [DAY_BITS-1:0] GREG_OFFSET     = DAY_BITS'(2299161 - 139810);

	// 400-year cycle: quotient by reciprocal, remainder below twice the cycle
	localparam int Q400_W  = DAY_BITS - 17;
	localparam int LO_W    = DAY_BITS / 2;
	localparam int HI_W    = DAY_BITS - LO_W;
	localparam int SUM_W   = DAY_BITS + Q400_W + 1;
	localparam int R400_W  = 19;
	localparam int RC_W    = 18;
	localparam logic [Q400_W-1:0] RECIP_400Y = Q400_W'((64'd1 << DAY_BITS) / 64'd146097);
	localparam logic [R400_W-1:0] D400_R     = R400_W'(146097);

	// Julian range: day count fits 22 bits, 4-year block by reciprocal
	localparam int JD_W     = 22;
	localparam int RECIP4_W = 12;
	localparam int JQ_W     = 11;
	localparam int JREM_W   = 12;
	localparam logic [RECIP4_W-1:0] RECIP_4Y = RECIP4_W'((64'd1 << JD_W) / 64'd1461);
	localparam logic [JREM_W-1:0]   D4_J     = JREM_W'(1461);

	// Century and 4-year split of a day within the 400-year cycle
	localparam int V_W    = 16;
	localparam int BLK_W  = 11;
	localparam int Q4_W   = 5;
	localparam int DOY_W  = 9;
	localparam int D4     = 1461;
	localparam int D100   = 36524;
	localparam logic [RC_W-1:0] CENT1_START = RC_W'(36525);
	localparam logic [RC_W-1:0] CENT2_START = RC_W'(36525 + 36524);
	localparam logic [RC_W-1:0] CENT3_START = RC_W'(36525 + 2 * 36524);

	// Year arithmetic
	localparam int YR_W = Q400_W + 9;
	localparam logic [YR_W-1:0] GREG_BASE_YEAR = YR_W'(1200);
	localparam logic [YR_W-1:0] BC_PIVOT       = YR_W'(4713);
	localparam logic [YR_W-1:0] AD_PIVOT       = YR_W'(4712);

	// First day of each month in a common year, zero based
	typedef logic [DOY_W-1:0] month_start_t [0:11];
	localparam month_start_t MONTH_START = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

endpackage

// ===== src/julian_day_to_calendar_date_top.sv =====
// An accepted input transaction passes through the stage registers s1 to s10 before its result shows on m_tvalid.
// One transaction per cycle while the output is not stalled, through the ten-stage datapath pipeline.
// A result not taken holds the whole pipeline; s_tready is low only while stalled.
// Reset (arst_n low) clears every stage valid flag at once; no result is pending.
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_top: day count to calendar date
// Splits a day count since 1 January 4713 BC into day, month, year and era,
// Julian rules up to 4 October 1582 and Gregorian rules after it.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [jdcd_pkg::IN_W-1:0]  s_tdata,   // day_number
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [jdcd_pkg::OUT_W-1:0] m_tdata    // day_of_month, month_number, year_number, before_christ
);
	import jdcd_pkg::*;

	logic                     en;
	logic [STAGES-1:0]        stage_vld_q;

	// Stage registers
	logic [DAY_BITS-1:0]      day_s1;
	logic                     jul_s2, jul_s3, jul_s4, jul_s5, jul_s6, jul_s7, jul_s8, jul_s9;
	logic [DAY_BITS-1:0]      t_s2;
	logic [JD_W-1:0]          jd_s2;
	logic [LO_W+Q400_W-1:0]   pplo_s3;
	logic [HI_W+Q400_W-1:0]   pphi_s3;
	logic [R400_W-1:0]        tlo_s3, tlo_s4, tlo_s5;
	logic [JD_W+RECIP4_W-1:0] jprod_s3;
	logic [JREM_W-1:0]        jdlo_s3, jdlo_s4, jdlo_s5;
	logic [Q400_W-1:0]        q400_s4, q400_s5, q400_s6;
	logic [JQ_W-1:0]          jq_s4, jq_s5, jq_s6, jq_s7;
	logic [R400_W-1:0]        qprod_s5;
	logic [JREM_W-1:0]        jprod2_s5;
	logic [RC_W-1:0]          r400_s6;
	logic [BLK_W-1:0]         jr_s6, jr_s7;
	logic [1:0]               c_s7;
	logic [V_W-1:0]           v_s7;
	logic [YR_W-1:0]          y400_s7;
	logic [Q4_W-1:0]          q4_s8;
	logic [BLK_W-1:0]         blk_s8;
	logic                     nlf_s8;
	logic [YR_W-1:0]          ybase_s8;
	logic [DOY_W-1:0]         doy_s9;
	logic                     leap_s9;
	logic [YR_W-1:0]          year_s9;
	logic [DOM_W-1:0]         dom_s10;
	logic [MON_W-1:0]         mon_s10;
	logic [YEAR_NUMBER_W-1:0] year_s10;
	logic                     bc_s10;

	// Next-stage values
	logic [SUM_W-1:0]         recip_sum;
	logic [R400_W-1:0]        rem400;
	logic [JREM_W-1:0]        rem4;
	logic [Q400_W-1:0]        q400_nx;
	logic [RC_W-1:0]          r400_nx;
	logic [JQ_W-1:0]          jq_nx;
	logic [BLK_W-1:0]         jr_nx;
	logic [1:0]               c_nx;
	logic [RC_W-1:0]          cent_off;
	logic [Q4_W-1:0]          q4_nx;
	logic [V_W-1:0]           blk_base;
	logic [BLK_W-1:0]         blk_nx;
	logic                     nlf_nx;
	logic [YR_W-1:0]          cent_years;
	logic [YR_W-1:0]          ybase_nx;
	logic [1:0]               yr_nx;
	logic [BLK_W-1:0]         yr_base;
	logic [DOY_W-1:0]         doy_nx;
	logic [MON_W-1:0]         mon_nx;
	logic [DOY_W-1:0]         mstart;
	logic [DOY_W-1:0]         cand;
	logic [YR_W-1:0]          year_nx;
	logic                     bc_nx;

	// The pipeline moves as one; it holds while a result waits unclaimed
	assign en       = !stage_vld_q[STAGES-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = stage_vld_q[STAGES-1];
	assign m_tdata  = OUT_W'({bc_s10, year_s10, mon_s10, dom_s10});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[STAGES-2:0], s_tvalid};
		end
	end

	// 400-year quotient from the reciprocal partial products
	assign recip_sum = (SUM_W'(pphi_s3) << LO_W) + SUM_W'(pplo_s3);

	// Remainder correction: the estimated quotients are low by at most one
	always_comb begin
		rem400 = tlo_s5 - qprod_s5;
		rem4   = jdlo_s5 - jprod2_s5;
		if (rem400 >= D400_R) begin
			q400_nx = q400_s5 + Q400_W'(1);
			r400_nx = RC_W'(rem400 - D400_R);
		end else begin
			q400_nx = q400_s5;
			r400_nx = RC_W'(rem400);
		end
		if (rem4 >= D4_J) begin
			jq_nx = jq_s5 + JQ_W'(1);
			jr_nx = BLK_W'(rem4 - D4_J);
		end else begin
			jq_nx = jq_s5;
			jr_nx = BLK_W'(rem4);
		end
	end

	// Century within the cycle; the first century is one day longer
	always_comb begin
		if (r400_s6 >= CENT3_START) begin
			c_nx     = 2'd3;
			cent_off = RC_W'(3 * D100);
		end else if (r400_s6 >= CENT2_START) begin
			c_nx     = 2'd2;
			cent_off = RC_W'(2 * D100);
		end else if (r400_s6 >= CENT1_START) begin
			c_nx     = 2'd1;
			cent_off = RC_W'(D100);
		end else begin
			c_nx     = 2'd0;
			cent_off = '0;
		end
	end

	// 4-year block within the century, then era-specific year base
	always_comb begin
		q4_nx    = '0;
		blk_base = '0;
		for (int k = 1; k <= 24; k++) begin
			if (v_s7 >= V_W'(k * D4)) begin
				q4_nx    = Q4_W'(k);
				blk_base = V_W'(k * D4);
			end
		end
		case (c_s7)
			2'd0:    cent_years = YR_W'(0);
			2'd1:    cent_years = YR_W'(100);
			2'd2:    cent_years = YR_W'(200);
			2'd3:    cent_years = YR_W'(300);
			default: cent_years = YR_W'(0);
		endcase
		if (jul_s7) begin
			blk_nx   = jr_s7;
			nlf_nx   = 1'b0;
			q4_nx    = '0;
			ybase_nx = YR_W'({jq_s7, 2'b00});
		end else begin
			blk_nx   = BLK_W'(v_s7 - blk_base);
			nlf_nx   = (c_s7 != 2'd0) && (q4_nx == '0);
			ybase_nx = GREG_BASE_YEAR + y400_s7 + cent_years;
		end
	end

	// Year within the block; a non-leap first block starts one day late
	always_comb begin
		if (blk_s8 >= BLK_W'(1096)) begin
			yr_nx   = 2'd3;
			yr_base = BLK_W'(1096);
		end else if (blk_s8 >= BLK_W'(731)) begin
			yr_nx   = 2'd2;
			yr_base = BLK_W'(731);
		end else if (blk_s8 >= BLK_W'(366)) begin
			yr_nx   = 2'd1;
			yr_base = BLK_W'(366);
		end else begin
			yr_nx   = 2'd0;
			yr_base = '0;
		end
		doy_nx = DOY_W'(blk_s8 - yr_base - BLK_W'((yr_nx == 2'd0) && nlf_s8));
	end

	// Month and era
	always_comb begin
		mon_nx = MON_W'(1);
		mstart = '0;
		for (int i = 1; i < 12; i++) begin
			cand = MONTH_START[i] + DOY_W'(leap_s9 && (i >= 2));
			if (doy_s9 >= cand) begin
				mon_nx = MON_W'(i + 1);
				mstart = cand;
			end
		end
		if (jul_s9 && (year_s9 < BC_PIVOT)) begin
			year_nx = BC_PIVOT - year_s9;
			bc_nx   = 1'b1;
		end else if (jul_s9) begin
			year_nx = year_s9 - AD_PIVOT;
			bc_nx   = 1'b0;
		end else begin
			year_nx = year_s9;
			bc_nx   = 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: input register
			day_s1    <= s_tdata[DAY_BITS-1:0];
			// s2: era split, offset from 1200
			jul_s2    <= (day_s1 <= LAST_JULIAN_DAY);
			t_s2      <= day_s1 - GREG_OFFSET;
			jd_s2     <= day_s1[JD_W-1:0];
			// s3: reciprocal partial products
			jul_s3    <= jul_s2;
			pplo_s3   <= (LO_W+Q400_W)'(t_s2[LO_W-1:0]) * (LO_W+Q400_W)'(RECIP_400Y);
			pphi_s3   <= (HI_W+Q400_W)'(t_s2[DAY_BITS-1:LO_W]) * (HI_W+Q400_W)'(RECIP_400Y);
			tlo_s3    <= t_s2[R400_W-1:0];
			jprod_s3  <= (JD_W+RECIP4_W)'(jd_s2) * (JD_W+RECIP4_W)'(RECIP_4Y);
			jdlo_s3   <= jd_s2[JREM_W-1:0];
			// s4: estimated quotients
			jul_s4    <= jul_s3;
			q400_s4   <= recip_sum[DAY_BITS +: Q400_W];
			jq_s4     <= jprod_s3[JD_W +: JQ_W];
			tlo_s4    <= tlo_s3;
			jdlo_s4   <= jdlo_s3;
			// s5: quotient times divisor, low bits only
			jul_s5    <= jul_s4;
			q400_s5   <= q400_s4;
			jq_s5     <= jq_s4;
			qprod_s5  <= R400_W'(q400_s4) * D400_R;
			jprod2_s5 <= JREM_W'(jq_s4) * D4_J;
			tlo_s5    <= tlo_s4;
			jdlo_s5   <= jdlo_s4;
			// s6: corrected quotients and remainders
			jul_s6    <= jul_s5;
			q400_s6   <= q400_nx;
			r400_s6   <= r400_nx;
			jq_s6     <= jq_nx;
			jr_s6     <= jr_nx;
			// s7: century, years from full cycles
			jul_s7    <= jul_s6;
			c_s7      <= c_nx;
			v_s7      <= V_W'(r400_s6 - cent_off);
			y400_s7   <= (YR_W'(q400_s6) << 8) + (YR_W'(q400_s6) << 7) + (YR_W'(q400_s6) << 4);
			jq_s7     <= jq_s6;
			jr_s7     <= jr_s6;
			// s8: 4-year block
			jul_s8    <= jul_s7;
			q4_s8     <= q4_nx;
			blk_s8    <= blk_nx;
			nlf_s8    <= nlf_nx;
			ybase_s8  <= ybase_nx;
			// s9: year within block, day of year
			jul_s9    <= jul_s8;
			doy_s9    <= doy_nx;
			leap_s9   <= (yr_nx == 2'd0) && !nlf_s8;
			year_s9   <= ybase_s8 + YR_W'({q4_s8, yr_nx});
			// s10: result register
			dom_s10   <= DOM_W'(doy_s9 - mstart + DOY_W'(1));
			mon_s10   <= mon_nx;
			year_s10  <= YEAR_NUMBER_W'(year_nx);
			bc_s10    <= bc_nx;
		end
	end

endmodule

// ===== src/jdcd_checker.sv =====
// ----------------------------------------------------------------------------
// jdcd_checker: port-level checks for the date converter
// Watches the stream ports of the top level; attached by a bind below.
// ----------------------------------------------------------------------------
module jdcd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [jdcd_pkg::OUT_W-1:0] m_tdata
);
	import jdcd_pkg::*;

	logic [DOM_W-1:0]         dom;
	logic [MON_W-1:0]         mon;
	logic [YEAR_NUMBER_W-1:0] year;
	logic                     bc;

	assign dom  = m_tdata[DOM_LSB +: DOM_W];
	assign mon  = m_tdata[MON_LSB +: MON_W];
	assign year = m_tdata[YEAR_LSB +: YEAR_NUMBER_W];
	assign bc   = m_tdata[BC_BIT];

	// A stalled result transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input is taken exactly when the pipeline can move
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output stall");

	// Every delivered date is well formed
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (dom != '0) && (mon != '0) && (mon <= MON_W'(12)) && (year != '0))
		else $error("malformed date");

	// BC years only reach back to 4713
	a_bc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && bc |-> (year <= YEAR_NUMBER_W'(4713)))
		else $error("BC year out of range");

endmodule

bind julian_day_to_calendar_date_top jdcd_checker u_jdcd_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for julian_day_to_calendar_date_top
// Drives day counts on the input stream and checks every calendar date
// returned on the output stream. Expected dates come from a behavioural
// calendar model held in the bench. A short table of edge dates runs first,
// then random days spread over the Julian range, the calendar switch, modern
// dates and the full width of the day count. Both stream sides get random
// gaps. A long output stall fills the pipeline, and pauses after the edge table
// and amid the random days let all pending results drain.
// ----------------------------------------------------------------------------
module testbench;

	import jdcd_pkg::*;

	// Calendar constants for the behavioural model
	localparam longint unsigned JULIAN_LAST    = 2299160;
	localparam longint unsigned DAYS_FROM_1200 = 139810;
	localparam longint unsigned CYCLE_400Y     = 146097;
	localparam longint unsigned CENTURY_DAYS   = 36524;
	localparam longint unsigned QUAD_DAYS      = 1461;
	localparam int unsigned     MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	localparam int RANDOM_DAYS = 1732;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [DOM_W-1:0]         dom;
		logic [MON_W-1:0]         mon;
		logic [YEAR_NUMBER_W-1:0] year;
		logic                     bc;
	} date_t;

	typedef struct packed {
		logic [DAY_BITS-1:0] day;
		logic                typed;   // 1: compare with want, 0: use the model
		date_t               want;
	} day_row_t;

	// Edge dates; typed rows carry their date, the rest go through the model
	localparam int NUM_ROWS = 20;
	localparam day_row_t EDGE_DAYS [NUM_ROWS] = '{
		'{39'd0,          1'b1, '{5'd1,  4'd1,  31'd4713, 1'b1}},  // first day
		'{39'd59,         1'b1, '{5'd29, 4'd2,  31'd4713, 1'b1}},  // leap day 4713 BC
		'{39'd60,         1'b0, '0},
		'{39'd365,        1'b1, '{5'd31, 4'd12, 31'd4713, 1'b1}},
		'{39'd366,        1'b1, '{5'd1,  4'd1,  31'd4712, 1'b1}},
		'{39'd1721058,    1'b1, '{5'd1,  4'd1,  31'd1,    1'b1}},  // 1 BC
		'{39'd1721117,    1'b0, '0},                               // leap day 1 BC
		'{39'd1721423,    1'b1, '{5'd31, 4'd12, 31'd1,    1'b1}},
		'{39'd1721424,    1'b1, '{5'd1,  4'd1,  31'd1,    1'b0}},  // 1 AD
		'{39'd2299160,    1'b1, '{5'd4,  4'd10, 31'd1582, 1'b0}},  // last Julian day
		'{39'd2299161,    1'b1, '{5'd15, 4'd10, 31'd1582, 1'b0}},  // first Gregorian day
		'{39'd2305507,    1'b0, '0},                               // 29 Feb 1600
		'{39'd2415079,    1'b0, '0},                               // 28 Feb 1900
		'{39'd2415080,    1'b0, '0},                               // 1 Mar 1900
		'{39'd2415385,    1'b0, '0},                               // 31 Dec 1900
		'{39'd2451604,    1'b0, '0},                               // 29 Feb 2000
		'{39'd2451910,    1'b0, '0},                               // 31 Dec 2000
		'{39'h2A_AAAA_AAAA, 1'b0, '0},
		'{39'h55_5555_5555, 1'b0, '0},
		'{39'h7F_FFFF_FFFF, 1'b0, '0}                              // largest count
	};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;

	date_t  dates_due [$];
	int     mismatches;
	logic   offer_typed;
	date_t  offer_want;
	bit     tx_quiet;
	bit     rx_quiet;
	int     hold_left;

	julian_day_to_calendar_date_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Splits an offset within a 4-year block into year index and day of year
	function automatic longint unsigned year_in_block(input longint unsigned off,
			input bit first_leap, output longint unsigned doy, output bit leap);
		longint unsigned first_len;
		first_len = first_leap ? 366 : 365;
		if (off < first_len) begin
			doy  = off;
			leap = first_leap;
			return 0;
		end
		off  = off - first_len;
		doy  = off % 365;
		leap = 1'b0;
		return 1 + off / 365;
	endfunction

	// Day of year to month and day of month
	function automatic void month_of(input longint unsigned doy, input bit leap,
			output logic [DOM_W-1:0] dom, output logic [MON_W-1:0] mon);
		longint unsigned len;
		int m;
		m = 0;
		while (m < 11) begin
			len = MONTH_DAYS[m] + ((m == 1 && leap) ? 1 : 0);
			if (doy < len)
				break;
			doy = doy - len;
			m++;
		end
		mon = MON_W'(m + 1);
		dom = DOM_W'(doy + 1);
	endfunction

	// Calendar date of a day count
	function automatic date_t calendar_date_of(input logic [DAY_BITS-1:0] day_in);
		longint unsigned day, t, doy, n, c, q4, yr, year;
		bit leap;
		date_t d;
		day  = day_in;
		d.bc = 1'b0;
		if (day <= JULIAN_LAST) begin
			// Julian: plain 4-year blocks, first year of each is leap
			n = (day / QUAD_DAYS) * 4 + year_in_block(day % QUAD_DAYS, 1'b1, doy, leap);
			if (n < 4713) begin
				year = 4713 - n;
				d.bc = 1'b1;
			end else begin
				year = n - 4712;
			end
		end else begin
			// Gregorian: counted from 1 January 1200 in 400-year cycles
			t    = day - (JULIAN_LAST + 1) + DAYS_FROM_1200;
			year = 1200 + (t / CYCLE_400Y) * 400;
			t    = t % CYCLE_400Y;
			if (t < CENTURY_DAYS + 1) begin
				c  = 0;
				q4 = t / QUAD_DAYS;
				yr = year_in_block(t % QUAD_DAYS, 1'b1, doy, leap);
			end else begin
				t = t - (CENTURY_DAYS + 1);
				c = 1 + t / CENTURY_DAYS;
				t = t % CENTURY_DAYS;
				if (t < QUAD_DAYS - 1) begin
					// century year itself is not leap
					q4 = 0;
					yr = year_in_block(t, 1'b0, doy, leap);
				end else begin
					t  = t - (QUAD_DAYS - 1);
					q4 = 1 + t / QUAD_DAYS;
					yr = year_in_block(t % QUAD_DAYS, 1'b1, doy, leap);
				end
			end
			year = year + c * 100 + q4 * 4 + yr;
		end
		month_of(doy, leap, d.dom, d.mon);
		d.year = YEAR_NUMBER_W'(year);
		return d;
	endfunction

	// Random day, spread over the interesting ranges
	function automatic logic [DAY_BITS-1:0] random_day();
		logic [63:0] wide;
		case ($urandom_range(3))
			0: return DAY_BITS'($urandom_range(2299160));
			1: return DAY_BITS'(2299160 - 3000 + $urandom_range(6000));
			2: return DAY_BITS'($urandom_range(5000000, 2299161));
			default: begin
				wide = {$urandom, $urandom};
				return wide[DAY_BITS-1:0];
			end
		endcase
	endfunction

	// Offer one day count and hold it until the block takes it
	task automatic send_day(input logic [DAY_BITS-1:0] day, input logic typed, input date_t want);
		@(negedge clk);
		while (!tx_quiet && $urandom_range(99) < 6) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid    = 1'b1;
		s_tdata     = IN_W'(day);
		offer_typed = typed;
		offer_want  = want;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stop offering and let every pending date come back
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (dates_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("testbench NOT OK");
		$finish;
	end

	// Receiver: random stalls, plus a counted hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready  = 1'b0;
				hold_left = hold_left - 1;
			end else begin
				m_tready = rx_quiet || ($urandom_range(99) >= 6);
			end
		end
	end

	// Scoreboard: log expected dates on input transactions, check on output ones
	always @(posedge clk) begin
		date_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				dates_due.push_back(offer_typed ? offer_want
					: calendar_date_of(s_tdata[DAY_BITS-1:0]));
			if (m_tvalid && m_tready) begin
				got.dom  = m_tdata[DOM_LSB +: DOM_W];
				got.mon  = m_tdata[MON_LSB +: MON_W];
				got.year = m_tdata[YEAR_LSB +: YEAR_NUMBER_W];
				got.bc   = m_tdata[BC_BIT];
				if (dates_due.size() == 0) begin
					$error("unexpected result transaction, m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					want = dates_due.pop_front();
					if (got.dom !== want.dom) begin
						$error("day_of_month: expected %0d, got %0d", want.dom, got.dom);
						mismatches++;
					end
					if (got.mon !== want.mon) begin
						$error("month_number: expected %0d, got %0d", want.mon, got.mon);
						mismatches++;
					end
					if (got.year !== want.year) begin
						$error("year_number: expected %0d, got %0d", want.year, got.year);
						mismatches++;
					end
					if (got.bc !== want.bc) begin
						$error("before_christ: expected %0d, got %0d", want.bc, got.bc);
						mismatches++;
					end
				end
			end
		end
	end

	// Stimulus
	initial begin
		int waited;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		offer_typed = 1'b0;
		offer_want  = '0;
		tx_quiet    = 1'b0;
		rx_quiet    = 1'b0;
		hold_left   = 0;
		mismatches  = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// edge dates
		for (int i = 0; i < NUM_ROWS; i++)
			send_day(EDGE_DAYS[i].day, EDGE_DAYS[i].typed, EDGE_DAYS[i].want);
		drain();

		// long output stall while input keeps coming, then random days
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < RANDOM_DAYS; i++) begin
			tx_quiet = (i >= 500 && i < 800);
			rx_quiet = tx_quiet;
			if (i == 1100)
				drain();
			send_day(random_day(), 1'b0, '0);
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// wind down
		@(negedge clk);
		s_tvalid = 1'b0;
		waited = 0;
		while (dates_due.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (STAGES + 4) @(negedge clk);
		if (dates_due.size() != 0) begin
			$error("%0d expected results never arrived", dates_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== julian_day_to_calendar_date_top.f =====
src/jdcd_pkg.sv
src/julian_day_to_calendar_date_top.sv
src/jdcd_checker.sv
verif/testbench.sv
